FILE: design/tbgq_pkg.sv
// shared types and constants of the touch and button gesture qualifier
`default_nettype none

package tbgq_pkg;

	// configuration register file
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TOL_W     = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_QUIET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TOL      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_HOLD    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_HOLD     = 3'd7;

	// register reset values
	localparam logic [CFG_W-1:0] RST_STABLE_TIME   = 16'd50;
	localparam logic [CFG_W-1:0] RST_RELEASE_QUIET = 16'd150;
	localparam logic [CFG_W-1:0] RST_HOLD_TIMEOUT  = 16'd1000;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE_TIME = 16'd180;
	localparam logic [CFG_W-1:0] RST_LONG_HOLD     = 16'd1500;
	localparam logic [TOL_W-1:0] RST_MOVE_TOL      = 12'd8;
	localparam logic [CFG_W-1:0] RST_POWER_HOLD    = 16'd3000;
	localparam logic [CFG_W-1:0] RST_BOOT_HOLD     = 16'd1500;

	// fixed limit on the wait for release
	localparam logic [CFG_W-1:0] RELEASE_TIMEOUT = 16'd500;

	// event codes on the result channel
	localparam int EV_W = 2;
	localparam logic [EV_W-1:0] EV_NONE = 2'd0;
	localparam logic [EV_W-1:0] EV_TAP  = 2'd1;
	localparam logic [EV_W-1:0] EV_HOME = 2'd2;

	// gesture state machine
	typedef enum logic [7:0] {
		M_INIT  = 8'b0000_0001,
		M_IDLE  = 8'b0000_0010,
		M_QUAL  = 8'b0000_0100,
		M_HOLD  = 8'b0000_1000,
		M_REL   = 8'b0001_0000,
		M_DEB   = 8'b0010_0000,
		M_BOOT  = 8'b0100_0000,
		M_BOOTW = 8'b1000_0000
	} mode_t;

endpackage

`default_nettype wire

FILE: design/touch_button_gesture_qualifier.sv
// touch and button gesture qualifier: tap, long press, home and power-off events
//
// Input channel s_*: one word per millisecond sample of the touch panel and the
// boot and power buttons. Output channel m_*: one word per event; a sample that
// raises no event produces no word. m_tuser carries the event kind (none when
// the word only reports power_off). Configuration is a plain write port, one
// register per cfg_addr, written at any edge with cfg_we high and expected to
// change only while the block is idle.
// Path: a sample is held in the input register; its event word is loaded into
// the result register, or the skid entry, when the step advances.
// Throughput: one sample per cycle unless stalled; all gesture, power and boot
// tracking for a sample is done in one pass between input and result registers.
// Stalls: a two-entry result buffer (result register plus skid) sits behind the
// step logic; s_tready drops only once the skid entry is taken, so a stalled
// receiver backs up the input after two pending events.
// Reset: registers return to their documented defaults, the gesture machine
// starts in the release wait, all timers clear and both buffers empty.
`default_nettype none

module touch_button_gesture_qualifier #(
	parameter int COORD_BITS = 12,
	parameter int TIMER_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// slave side: touch_down, touch_x, touch_y, boot_button, power_button
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [((2*COORD_BITS+3+7)/8)*8-1:0] s_tdata,
	// master side: tap_x, tap_y, long_hold, power_off
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
	// master side: event_kind
	output logic [tbgq_pkg::EV_W-1:0] m_tuser,
	// configuration writes
	input  wire logic cfg_we,
	input  wire logic [tbgq_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [tbgq_pkg::CFG_W-1:0] cfg_wdata
);
	import tbgq_pkg::*;

	localparam int CB     = COORD_BITS;
	localparam int TB     = TIMER_BITS;
	localparam int OUT_W  = 2*CB + 2;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
	localparam int CMPW   = (TB > CFG_W) ? TB : CFG_W;
	localparam int DW     = (CB > TOL_W) ? CB : TOL_W;

	typedef struct packed {
		logic          done;
		logic [TB-1:0] pt;
		logic [TB-1:0] rg;
	} rw_t;

	typedef struct packed {
		logic [EV_W-1:0] kind;
		logic [CB-1:0]   tx;
		logic [CB-1:0]   ty;
		logic            lp;
		logic            poff;
	} res_t;

	// saturating millisecond counter step
	function automatic logic [TB-1:0] inc_sat(input logic [TB-1:0] t);
		return (t == {TB{1'b1}}) ? t : t + TB'(1);
	endfunction

	// timer against a register, both widened to a common width
	function automatic logic ge_cfg(input logic [TB-1:0] t, input logic [CFG_W-1:0] c);
		return CMPW'(t) >= CMPW'(c);
	endfunction

	// one sample of the release wait
	function automatic rw_t rel_wait(input logic down, input logic [TB-1:0] pt,
			input logic [TB-1:0] rg, input logic [CFG_W-1:0] quiet);
		rw_t r;
		r.done = 1'b0;
		r.pt   = pt;
		r.rg   = rg;
		if (down) begin
			r.rg = '0;
		end else begin
			r.rg = inc_sat(rg);
			if (ge_cfg(r.rg - TB'(1), quiet))
				r.done = 1'b1;
		end
		if (!r.done) begin
			if (ge_cfg(pt, RELEASE_TIMEOUT))
				r.done = 1'b1;
			else
				r.pt = inc_sat(pt);
		end
		return r;
	endfunction

	// configuration registers
	logic [CFG_W-1:0] stable_time_q, release_quiet_q, hold_timeout_q, debounce_time_q;
	logic [CFG_W-1:0] long_hold_q, power_hold_q, boot_hold_q;
	logic [TOL_W-1:0] move_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_time_q   <= RST_STABLE_TIME;
			release_quiet_q <= RST_RELEASE_QUIET;
			hold_timeout_q  <= RST_HOLD_TIMEOUT;
			debounce_time_q <= RST_DEBOUNCE_TIME;
			long_hold_q     <= RST_LONG_HOLD;
			move_tol_q      <= RST_MOVE_TOL;
			power_hold_q    <= RST_POWER_HOLD;
			boot_hold_q     <= RST_BOOT_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_STABLE_TIME:   stable_time_q   <= cfg_wdata;
				CFG_RELEASE_QUIET: release_quiet_q <= cfg_wdata;
				CFG_HOLD_TIMEOUT:  hold_timeout_q  <= cfg_wdata;
				CFG_DEBOUNCE_TIME: debounce_time_q <= cfg_wdata;
				CFG_LONG_HOLD:     long_hold_q     <= cfg_wdata;
				CFG_MOVE_TOL:      move_tol_q      <= cfg_wdata[TOL_W-1:0];
				CFG_POWER_HOLD:    power_hold_q    <= cfg_wdata;
				CFG_BOOT_HOLD:     boot_hold_q     <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	// input register
	logic          valid_s1;
	logic          down_s1, boot_s1, pwr_s1;
	logic [CB-1:0] x_s1, y_s1;
	logic          skid_valid_q;
	logic          s_accept, advance;

	assign s_tready = !skid_valid_q;
	assign s_accept = s_tvalid && s_tready;
	assign advance  = valid_s1 && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			down_s1 <= s_tdata[0];
			x_s1    <= s_tdata[CB:1];
			y_s1    <= s_tdata[2*CB:CB+1];
			boot_s1 <= s_tdata[2*CB+1];
			pwr_s1  <= s_tdata[2*CB+2];
		end
	end

	// gesture, boot and power state
	mode_t         mode_q, mode_n;
	logic [TB-1:0] phase_q, phase_n, guard_q, guard_n, press_q, press_n;
	logic [TB-1:0] power_timer_q, power_timer_n, boot_timer_q, boot_timer_n;
	logic [CB-1:0] anchor_x_q, anchor_x_n, anchor_y_q, anchor_y_n;
	logic          power_latched_q, power_latched_n;
	res_t          res;
	logic          has_res;
	logic [CB-1:0] dx, dy;

	assign dx = (x_s1 > anchor_x_q) ? x_s1 - anchor_x_q : anchor_x_q - x_s1;
	assign dy = (y_s1 > anchor_y_q) ? y_s1 - anchor_y_q : anchor_y_q - y_s1;

	// one sample step of all trackers
	always_comb begin
		rw_t  rw;
		logic skip_idle;
		rw              = '0;
		skip_idle       = 1'b0;
		mode_n          = mode_q;
		phase_n         = phase_q;
		guard_n         = guard_q;
		press_n         = press_q;
		power_timer_n   = power_timer_q;
		power_latched_n = power_latched_q;
		boot_timer_n    = boot_timer_q;
		anchor_x_n      = anchor_x_q;
		anchor_y_n      = anchor_y_q;
		res             = '0;

		// power button monitor
		if (pwr_s1) begin
			if (!power_latched_q) begin
				if (ge_cfg(power_timer_q, power_hold_q)) begin
					res.poff        = 1'b1;
					power_latched_n = 1'b1;
				end
				power_timer_n = inc_sat(power_timer_q);
			end
		end else begin
			power_timer_n   = '0;
			power_latched_n = 1'b0;
		end

		// debounce after a tap
		if (mode_n == M_DEB) begin
			if (ge_cfg(phase_n, debounce_time_q)) begin
				mode_n  = M_INIT;
				phase_n = '0;
				guard_n = '0;
			end else begin
				phase_n = inc_sat(phase_n);
			end
		end

		// release wait before idle
		if (mode_n == M_INIT) begin
			rw      = rel_wait(down_s1, phase_n, guard_n, release_quiet_q);
			phase_n = rw.pt;
			guard_n = rw.rg;
			if (rw.done)
				mode_n = M_IDLE;
		end

		// holding a qualified touch
		if (mode_n == M_HOLD) begin
			press_n = inc_sat(press_n);
			phase_n = inc_sat(phase_n);
			if (!down_s1 || ge_cfg(phase_n, hold_timeout_q)) begin
				mode_n  = M_REL;
				phase_n = '0;
				guard_n = '0;
			end
		end else if (mode_n == M_REL) begin
			press_n = inc_sat(press_n);
		end

		// release wait that ends in a tap
		if (mode_n == M_REL) begin
			rw      = rel_wait(down_s1, phase_n, guard_n, release_quiet_q);
			phase_n = rw.pt;
			guard_n = rw.rg;
			if (rw.done) begin
				res.kind = EV_TAP;
				res.tx   = anchor_x_n;
				res.ty   = anchor_y_n;
				res.lp   = ge_cfg(press_n, long_hold_q);
				mode_n   = M_DEB;
				phase_n  = '0;
			end
		end

		// qualifying a fresh touch
		if (mode_n == M_QUAL) begin
			phase_n = inc_sat(phase_n);
			if (ge_cfg(phase_n, stable_time_q)) begin
				mode_n  = M_HOLD;
				phase_n = '0;
				press_n = '0;
			end else if (!down_s1 || DW'(dx) > DW'(move_tol_q) ||
					DW'(dy) > DW'(move_tol_q)) begin
				mode_n    = M_IDLE;
				skip_idle = 1'b1;
			end
		end

		// boot button hold
		if (mode_n == M_BOOT) begin
			if (!boot_s1) begin
				mode_n = M_IDLE;
			end else begin
				boot_timer_n = inc_sat(boot_timer_n);
				if (ge_cfg(boot_timer_n, boot_hold_q))
					mode_n = M_BOOTW;
			end
		end else if (mode_n == M_BOOTW) begin
			if (!boot_s1) begin
				res.kind = EV_HOME;
				mode_n   = M_INIT;
				phase_n  = '0;
				guard_n  = '0;
			end
		end

		// idle: start a boot hold or a touch
		if (mode_n == M_IDLE && !skip_idle) begin
			if (boot_s1) begin
				boot_timer_n = '0;
				mode_n       = (boot_hold_q == '0) ? M_BOOTW : M_BOOT;
			end else if (down_s1) begin
				anchor_x_n = x_s1;
				anchor_y_n = y_s1;
				phase_n    = '0;
				mode_n     = M_QUAL;
			end
		end
	end

	assign has_res = (res.kind != EV_NONE) || res.poff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= M_INIT;
			phase_q         <= '0;
			guard_q         <= '0;
			press_q         <= '0;
			power_timer_q   <= '0;
			power_latched_q <= 1'b0;
			boot_timer_q    <= '0;
			anchor_x_q      <= '0;
			anchor_y_q      <= '0;
		end else if (advance) begin
			mode_q          <= mode_n;
			phase_q         <= phase_n;
			guard_q         <= guard_n;
			press_q         <= press_n;
			power_timer_q   <= power_timer_n;
			power_latched_q <= power_latched_n;
			boot_timer_q    <= boot_timer_n;
			anchor_x_q      <= anchor_x_n;
			anchor_y_q      <= anchor_y_n;
		end
	end

	// result register and skid entry
	logic m_valid_q;
	res_t out_q, skid_q;
	logic push, pop;

	assign push = advance && has_res;
	assign pop  = m_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (!m_valid_q || pop) begin
			m_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (!m_valid_q || pop) begin
			if (push)
				out_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = OUT_TW'({out_q.poff, out_q.lp, out_q.ty, out_q.tx});

	// skid entry is only ever filled behind a full result register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> m_valid_q)
		else $error("skid entry valid while result register empty");

	// a word with no event must be a power-off report
	a_no_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_q.kind == EV_NONE) |-> out_q.poff)
		else $error("result word carries no event");

	// tap fields stay clear on non-tap words
	a_tap_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && out_q.kind != EV_TAP) |->
		(out_q.tx == '0 && out_q.ty == '0 && !out_q.lp))
		else $error("tap fields set on a non-tap word");

	// a held sample is not lost while the result buffer is full
	a_hold_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && skid_valid_q) |=> valid_s1)
		else $error("input sample dropped during stall");

	// power-off latch is only set after counting
	a_power_latch: assert property (@(posedge clk) disable iff (!arst_n)
		power_latched_q |-> (power_timer_q != '0))
		else $error("power latch set with a cleared hold timer");

endmodule

`default_nettype wire

FILE: sim/touch_button_gesture_qualifier_test.sv
// self-checking stream testbench for the touch and button gesture qualifier
`default_nettype none

module touch_button_gesture_qualifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tbgq_pkg::*;

	localparam int NUM_REGS       = 1 << CFG_IDX_W;
	localparam int TIMER_MAX      = 65535;
	localparam int COORD_MAX      = 4095;
	localparam int DRAIN_CYCLES   = 6;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int PRINT_CAP      = 30;

	// one millisecond sample, lowest bit first: down, x, y, boot, power
	typedef struct packed {
		logic        power_button;
		logic        boot_button;
		logic [11:0] y;
		logic [11:0] x;
		logic        down;
	} sample_t;

	// one event word as seen on the result side
	typedef struct packed {
		logic [EV_W-1:0] kind;
		logic [11:0]     tap_x;
		logic [11:0]     tap_y;
		logic            long_hold;
		logic            power_off;
	} gesture_word_t;

	typedef logic [NUM_REGS-1:0][CFG_W-1:0] reg_set_t;

	// gesture predictor plus the queue of event words still to arrive
	class gesture_scoreboard;
		int unsigned   cfg_reg [NUM_REGS];
		mode_t         mode;
		int unsigned   phase_t, guard_t, press_t, power_t, boot_t;
		logic [11:0]   anchor_x, anchor_y;
		bit            power_latched;
		gesture_word_t pending [$];
		int            errors, samples, words, taps, long_taps, homes, power_offs;

		function new();
			cfg_reg[CFG_STABLE_TIME]   = RST_STABLE_TIME;
			cfg_reg[CFG_RELEASE_QUIET] = RST_RELEASE_QUIET;
			cfg_reg[CFG_HOLD_TIMEOUT]  = RST_HOLD_TIMEOUT;
			cfg_reg[CFG_DEBOUNCE_TIME] = RST_DEBOUNCE_TIME;
			cfg_reg[CFG_LONG_HOLD]     = RST_LONG_HOLD;
			cfg_reg[CFG_MOVE_TOL]      = RST_MOVE_TOL;
			cfg_reg[CFG_POWER_HOLD]    = RST_POWER_HOLD;
			cfg_reg[CFG_BOOT_HOLD]     = RST_BOOT_HOLD;
			mode = M_INIT;
			phase_t = 0;
			guard_t = 0;
			press_t = 0;
			power_t = 0;
			boot_t = 0;
			anchor_x = '0;
			anchor_y = '0;
			power_latched = 1'b0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			cfg_reg[idx] = (idx == CFG_MOVE_TOL) ? int'(val[TOL_W-1:0]) : int'(val);
		endfunction

		function int unsigned bump(int unsigned v);
			return (v < TIMER_MAX) ? v + 1 : TIMER_MAX;
		endfunction

		function int unsigned axis_gap(logic [11:0] a, logic [11:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// one sample of the release wait, true once released or timed out
		function bit release_done(bit down);
			if (down) begin
				guard_t = 0;
			end else begin
				guard_t = bump(guard_t);
				if (guard_t - 1 >= cfg_reg[CFG_RELEASE_QUIET])
					return 1'b1;
			end
			if (phase_t >= RELEASE_TIMEOUT)
				return 1'b1;
			phase_t = bump(phase_t);
			return 1'b0;
		endfunction

		// advance the gesture state by one accepted sample
		function void note_sample(sample_t s);
			gesture_word_t w;
			bit skip_idle;
			int unsigned tol;
			w = '0;
			w.kind = EV_NONE;
			skip_idle = 1'b0;
			tol = cfg_reg[CFG_MOVE_TOL];
			samples++;

			// power monitor runs regardless of the gesture state
			if (s.power_button) begin
				if (!power_latched) begin
					if (power_t >= cfg_reg[CFG_POWER_HOLD]) begin
						w.power_off = 1'b1;
						power_latched = 1'b1;
					end
					power_t = bump(power_t);
				end
			end else begin
				power_t = 0;
				power_latched = 1'b0;
			end

			if (mode == M_DEB) begin
				if (phase_t >= cfg_reg[CFG_DEBOUNCE_TIME]) begin
					mode = M_INIT;
					phase_t = 0;
					guard_t = 0;
				end else begin
					phase_t = bump(phase_t);
				end
			end
			if (mode == M_INIT && release_done(s.down))
				mode = M_IDLE;

			// held touch, then the release wait that ends in a tap
			if (mode == M_HOLD) begin
				press_t = bump(press_t);
				phase_t = bump(phase_t);
				if (!s.down || phase_t >= cfg_reg[CFG_HOLD_TIMEOUT]) begin
					mode = M_REL;
					phase_t = 0;
					guard_t = 0;
				end
			end else if (mode == M_REL) begin
				press_t = bump(press_t);
			end
			if (mode == M_REL && release_done(s.down)) begin
				w.kind = EV_TAP;
				w.tap_x = anchor_x;
				w.tap_y = anchor_y;
				w.long_hold = (press_t >= cfg_reg[CFG_LONG_HOLD]);
				mode = M_DEB;
				phase_t = 0;
			end

			// qualifying the first touch
			if (mode == M_QUAL) begin
				phase_t = bump(phase_t);
				if (phase_t >= cfg_reg[CFG_STABLE_TIME]) begin
					mode = M_HOLD;
					phase_t = 0;
					press_t = 0;
				end else if (!s.down || axis_gap(s.x, anchor_x) > tol ||
						axis_gap(s.y, anchor_y) > tol) begin
					mode = M_IDLE;
					skip_idle = 1'b1;
				end
			end

			// boot button hold, home on release
			if (mode == M_BOOT) begin
				if (!s.boot_button) begin
					mode = M_IDLE;
				end else begin
					boot_t = bump(boot_t);
					if (boot_t >= cfg_reg[CFG_BOOT_HOLD])
						mode = M_BOOTW;
				end
			end else if (mode == M_BOOTW) begin
				if (!s.boot_button) begin
					w.kind = EV_HOME;
					mode = M_INIT;
					phase_t = 0;
					guard_t = 0;
				end
			end

			if (mode == M_IDLE && !skip_idle) begin
				if (s.boot_button) begin
					boot_t = 0;
					mode = (cfg_reg[CFG_BOOT_HOLD] == 0) ? M_BOOTW : M_BOOT;
				end else if (s.down) begin
					anchor_x = s.x;
					anchor_y = s.y;
					phase_t = 0;
					mode = M_QUAL;
				end
			end

			if (w.kind != EV_NONE || w.power_off)
				pending.push_back(w);
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch: %s", what);
		endtask

		// compare one received word with the oldest predicted one
		task check_word(logic [EV_W-1:0] kind, logic [31:0] data);
			gesture_word_t got, want;
			got.kind = kind;
			got.tap_x = data[11:0];
			got.tap_y = data[23:12];
			got.long_hold = data[24];
			got.power_off = data[25];
			words++;
			if (got.kind == EV_TAP) taps++;
			if (got.kind == EV_TAP && got.long_hold) long_taps++;
			if (got.kind == EV_HOME) homes++;
			if (got.power_off) power_offs++;
			if (pending.size() == 0) begin
				report($sformatf("word %0d arrived with nothing predicted (kind %0d)",
					words, got.kind));
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("word %0d kind %0d, predicted %0d", words, got.kind, want.kind));
			if (got.tap_x !== want.tap_x)
				report($sformatf("word %0d tap_x %0d, predicted %0d", words, got.tap_x,
					want.tap_x));
			if (got.tap_y !== want.tap_y)
				report($sformatf("word %0d tap_y %0d, predicted %0d", words, got.tap_y,
					want.tap_y));
			if (got.long_hold !== want.long_hold)
				report($sformatf("word %0d long_hold %b, predicted %b", words,
					got.long_hold, want.long_hold));
			if (got.power_off !== want.power_off)
				report($sformatf("word %0d power_off %b, predicted %b", words,
					got.power_off, want.power_off));
		endtask
	endclass

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [31:0]     s_tdata;   // touch_down, touch_x, touch_y, boot_button, power_button
	logic            m_tvalid;
	logic            m_tready;
	logic [31:0]     m_tdata;   // tap_x, tap_y, long_hold, power_off
	logic [EV_W-1:0] m_tuser;   // event_kind
	logic            cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]     cfg_wdata;

	gesture_scoreboard board = new();
	sample_t stim_q [$];
	int      sender_idle_pct = 0;
	int      receiver_stall_pct = 0;
	bit      pressure_req;
	bit      holdoff;
	int      cycles = 0;

	touch_button_gesture_qualifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic reg_set_t make_set(int stable, int quiet, int hold, int deb,
			int long_ms, int tol, int pwr, int boot);
		reg_set_t r;
		r[CFG_STABLE_TIME]   = CFG_W'(stable);
		r[CFG_RELEASE_QUIET] = CFG_W'(quiet);
		r[CFG_HOLD_TIMEOUT]  = CFG_W'(hold);
		r[CFG_DEBOUNCE_TIME] = CFG_W'(deb);
		r[CFG_LONG_HOLD]     = CFG_W'(long_ms);
		r[CFG_MOVE_TOL]      = CFG_W'(tol);
		r[CFG_POWER_HOLD]    = CFG_W'(pwr);
		r[CFG_BOOT_HOLD]     = CFG_W'(boot);
		return r;
	endfunction

	function automatic logic [11:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 12'(COORD_MAX);
			default: return 12'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	// coordinate within tolerance of c
	function automatic logic [11:0] near(logic [11:0] c, int unsigned tol);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * tol)) - int'(tol);
		if (v < 0) v = 0;
		if (v > COORD_MAX) v = COORD_MAX;
		return v[11:0];
	endfunction

	// coordinate just past tolerance, where the axis leaves room
	function automatic logic [11:0] away(logic [11:0] c, int unsigned tol);
		int v;
		v = int'(c);
		if (v + int'(tol) + 1 <= COORD_MAX)
			return 12'(v + int'(tol) + 1);
		if (v >= int'(tol) + 1)
			return 12'(v - int'(tol) - 1);
		return c;
	endfunction

	function automatic sample_t loose(bit d, bit b, bit p);
		sample_t s;
		s.down = d;
		s.x = 12'($urandom_range(0, COORD_MAX));
		s.y = 12'($urandom_range(0, COORD_MAX));
		s.boot_button = b;
		s.power_button = p;
		return s;
	endfunction

	task automatic push_sample(bit d, logic [11:0] x, logic [11:0] y, bit b, bit p,
			int reps);
		sample_t s;
		s = '{power_button: p, boot_button: b, y: y, x: x, down: d};
		repeat (reps) stim_q.push_back(s);
	endtask

	// one random gesture: a touch, a boot press, a power press or noise
	task automatic queue_burst();
		int unsigned pick, tol, len, gap;
		logic [11:0] bx, by;
		logic [31:0] r;
		bit pwr, drift;
		sample_t s;
		pick = $urandom_range(0, 99);
		tol = board.cfg_reg[CFG_MOVE_TOL];
		pwr = ($urandom_range(0, 4) == 0);
		bx = pick_coord();
		by = pick_coord();
		if (pick < 55) begin
			len = $urandom_range(1, 12);
			drift = ($urandom_range(0, 6) == 0);
			for (int i = 0; i < len; i++) begin
				s = '{power_button: pwr, boot_button: 1'b0, y: near(by, tol),
					x: near(bx, tol), down: 1'b1};
				if (drift && i == 1)
					s.x = away(bx, tol);
				stim_q.push_back(s);
			end
			gap = $urandom_range(0, 8);
			repeat (gap) stim_q.push_back(loose(1'b0, 1'b0, pwr));
		end else if (pick < 75) begin
			len = $urandom_range(1, 8);
			repeat (len) stim_q.push_back(loose($urandom_range(0, 3) == 0, 1'b1, pwr));
			gap = $urandom_range(0, 4);
			repeat (gap) stim_q.push_back(loose(1'b0, 1'b0, pwr));
		end else if (pick < 85) begin
			len = $urandom_range(1, 10);
			repeat (len) stim_q.push_back(loose(1'b0, 1'b0, 1'b1));
			stim_q.push_back(loose(1'b0, 1'b0, 1'b0));
		end else begin
			len = $urandom_range(1, 6);
			repeat (len) begin
				r = $urandom;
				s = r[26:0];
				stim_q.push_back(s);
			end
		end
	endtask

	// offer one word on the input side and wait for its acceptance
	task automatic drive_sample(sample_t s);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, s};
		do @(posedge clk); while (!s_tready);
		board.note_sample(s);
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_registers(reg_set_t regs);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= CFG_IDX_W'(i);
			cfg_wdata <= regs[i];
			board.set_register(CFG_IDX_W'(i), regs[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(reg_set_t regs, int send_idle, int recv_stall, int count,
			bit squeeze);
		drain();
		load_registers(regs);
		sender_idle_pct = send_idle;
		receiver_stall_pct = recv_stall;
		if (squeeze) pressure_req <= 1'b1;
		stim_q.delete();
		for (int n = 0; n < count; n++) begin
			if (stim_q.size() == 0) queue_burst();
			drive_sample(stim_q.pop_front());
		end
		s_tvalid <= 1'b0;
	endtask

	// result side: check accepted words, then pick the next ready level
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_word(m_tuser, m_tdata);
			m_tready <= !holdoff && ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// long output stall so the block fills up and backs up its input
	initial begin
		holdoff <= 1'b0;
		wait (pressure_req);
		@(posedge clk);
		holdoff <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		holdoff <= 1'b0;
	end

	// run limit
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		reg_set_t fast_set, zero_set, max_set, mid_set;
		fast_set = make_set(2, 1, 6, 1, 5, 3, 2, 2);
		zero_set = make_set(0, 0, 0, 0, 0, 0, 0, 0);
		max_set  = make_set(TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX,
			COORD_MAX, TIMER_MAX, TIMER_MAX);
		mid_set  = make_set(4, 3, 12, 5, 9, 40, 6, 3);

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		pressure_req <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: release wait, a corner tap, a touch during debounce, home, power-off
		load_registers(fast_set);
		push_sample(1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 2);
		push_sample(1'b1, 12'd0, 12'd0, 1'b0, 1'b0, 3);
		push_sample(1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 3);
		push_sample(1'b1, 12'd4095, 12'd4095, 1'b0, 1'b0, 1);
		push_sample(1'b1, 12'd4091, 12'd4095, 1'b0, 1'b0, 1);
		push_sample(1'b1, 12'd4095, 12'd4095, 1'b0, 1'b0, 7);
		push_sample(1'b0, 12'd4095, 12'd4095, 1'b0, 1'b0, 3);
		push_sample(1'b0, 12'd2730, 12'd1365, 1'b1, 1'b0, 3);
		push_sample(1'b0, 12'd2730, 12'd1365, 1'b0, 1'b0, 1);
		push_sample(1'b0, 12'd1365, 12'd2730, 1'b0, 1'b1, 4);
		push_sample(1'b0, 12'd0, 12'd0, 1'b0, 1'b0, 1);
		while (stim_q.size() != 0) drive_sample(stim_q.pop_front());
		s_tvalid <= 1'b0;

		// random gestures under several register settings and idling patterns
		run_phase(fast_set, 0, 0, 200, 1'b0);
		run_phase(fast_set, 82, 0, 150, 1'b0);
		run_phase(zero_set, 0, 82, 150, 1'b0);
		run_phase(max_set, 13, 13, 100, 1'b0);
		run_phase(mid_set, 13, 13, 200, 1'b0);
		run_phase(fast_set, 0, 0, 100, 1'b1);
		drain();

		$display("ran %0d samples, %0d words: %0d taps (%0d long), %0d home, %0d power-off",
			board.samples, board.words, board.taps, board.long_taps, board.homes,
			board.power_offs);
		$display("short, zero, maximum and mid times; four idling mixes; one long stall");
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
